// ----- rtl/core/ftpe_pkg.sv -----
// Shared constants and polynomial coefficient tables for the food thermal property evaluator.
`default_nettype none

package ftpe_pkg;

  // Number of configured mass fractions and order of the fraction registers
  localparam int NFRAC    = 7;
  localparam int NCOMP    = 6;  // components that carry conductivity and density
  localparam int FRAC_W   = 17;
  localparam int ADDR_W   = 3;

  localparam int REG_PROTEIN = 0;
  localparam int REG_FAT     = 1;
  localparam int REG_CARB    = 2;
  localparam int REG_FIBER   = 3;
  localparam int REG_ASH     = 4;
  localparam int REG_WATER   = 5;
  localparam int REG_ICE     = 6;

  // Polynomial table layout: cp of five solids, water above and below 0 C,
  // ice, then conductivity of six components, then density of six components
  localparam int NPOLY = 20;
  localparam int P_WHI = 5;
  localparam int P_WLO = 6;
  localparam int P_ICE = 7;
  localparam int P_K   = 8;
  localparam int P_RHO = 14;

  localparam int ZERO_C_Q16 = 17901158;
  localparam int HC_MAX     = 393216;
  localparam int K_MAX      = 163840;
  localparam int RHO_MAX    = 655360;

  // Signed Q32 coefficients, magnitude rounded half up
  localparam longint POLY_A [NPOLY] = '{
    longint'(((64'd20082 << 32) + 64'd5000) / 64'd10000),
    longint'(((64'd19842 << 32) + 64'd5000) / 64'd10000),
    longint'(((64'd15488 << 32) + 64'd5000) / 64'd10000),
    longint'(((64'd18459 << 32) + 64'd5000) / 64'd10000),
    longint'(((64'd10926 << 32) + 64'd5000) / 64'd10000),
    longint'(((64'd41289 << 32) + 64'd5000) / 64'd10000),
    longint'(((64'd41289 << 32) + 64'd5000) / 64'd10000),
    longint'(((64'd20623 << 32) + 64'd5000) / 64'd10000),
    longint'(((64'd17881 << 32) + 64'd50000) / 64'd100000),
    longint'(((64'd18071 << 32) + 64'd50000) / 64'd100000),
    longint'(((64'd20141 << 32) + 64'd50000) / 64'd100000),
    longint'(((64'd18331 << 32) + 64'd50000) / 64'd100000),
    longint'(((64'd32962 << 32) + 64'd50000) / 64'd100000),
    longint'(((64'd57109 << 32) + 64'd50000) / 64'd100000),
    longint'(((64'd13299 << 32) + 64'd5) / 64'd10),
    longint'(((64'd92559 << 32) + 64'd50) / 64'd100),
    longint'(((64'd15991 << 32) + 64'd5) / 64'd10),
    longint'(((64'd13115 << 32) + 64'd5) / 64'd10),
    longint'(((64'd24238 << 32) + 64'd5) / 64'd10),
    longint'(((64'd99718 << 32) + 64'd50) / 64'd100)
  };

  localparam longint POLY_B [NPOLY] = '{
    longint'(((64'd12089 << 32) + 64'd5000000) / 64'd10000000),
    longint'(((64'd14733 << 32) + 64'd50000000) / 64'd100000000),
    longint'(((64'd19625 << 32) + 64'd5000000) / 64'd10000000),
    longint'(((64'd18306 << 32) + 64'd5000000) / 64'd10000000),
    longint'(((64'd18896 << 32) + 64'd5000000) / 64'd10000000),
    -longint'(((64'd90864 << 32) + 64'd500000000) / 64'd1000000000),
    -longint'(((64'd53062 << 32) + 64'd5000000) / 64'd10000000),
    longint'(((64'd60769 << 32) + 64'd5000000) / 64'd10000000),
    longint'(((64'd11958 << 32) + 64'd5000000) / 64'd10000000),
    -longint'(((64'd27604 << 32) + 64'd50000000) / 64'd100000000),
    longint'(((64'd13874 << 32) + 64'd5000000) / 64'd10000000),
    longint'(((64'd12497 << 32) + 64'd5000000) / 64'd10000000),
    longint'(((64'd14011 << 32) + 64'd5000000) / 64'd10000000),
    longint'(((64'd1762 << 32) + 64'd500000) / 64'd1000000),
    -longint'(((64'd5184 << 32) + 64'd5000) / 64'd10000),
    -longint'(((64'd41757 << 32) + 64'd50000) / 64'd100000),
    -longint'(((64'd31046 << 32) + 64'd50000) / 64'd100000),
    -longint'(((64'd36589 << 32) + 64'd50000) / 64'd100000),
    -longint'(((64'd28063 << 32) + 64'd50000) / 64'd100000),
    longint'(((64'd31439 << 32) + 64'd5000000) / 64'd10000000)
  };

  localparam longint POLY_C [NPOLY] = '{
    -longint'(((64'd13129 << 32) + 64'd5000000000) / 64'd10000000000),
    -longint'(((64'd48008 << 32) + 64'd5000000000) / 64'd10000000000),
    -longint'(((64'd59399 << 32) + 64'd5000000000) / 64'd10000000000),
    -longint'(((64'd46509 << 32) + 64'd5000000000) / 64'd10000000000),
    -longint'(((64'd36817 << 32) + 64'd5000000000) / 64'd10000000000),
    longint'(((64'd54731 << 32) + 64'd5000000000) / 64'd10000000000),
    longint'(((64'd99516 << 32) + 64'd50000000) / 64'd100000000),
    longint'(0),
    -longint'(((64'd27178 << 32) + 64'd5000000000) / 64'd10000000000),
    -longint'(((64'd17749 << 32) + 64'd50000000000) / 64'd100000000000),
    -longint'(((64'd43312 << 32) + 64'd5000000000) / 64'd10000000000),
    -longint'(((64'd31683 << 32) + 64'd5000000000) / 64'd10000000000),
    -longint'(((64'd29069 << 32) + 64'd5000000000) / 64'd10000000000),
    -longint'(((64'd6703 << 32) + 64'd500000000) / 64'd1000000000),
    longint'(0),
    longint'(0),
    longint'(0),
    longint'(0),
    longint'(0),
    -longint'(((64'd37574 << 32) + 64'd5000000) / 64'd10000000)
  };

endpackage

`default_nettype wire

// ----- rtl/core/ftpe_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none

module ftpe_div #(
  parameter int NW = 57,
  parameter int DW = 37,
  parameter int QW = 25
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          ovf
);

  logic [DW-1:0] rem   [QW];
  logic [QW-1:0] lo    [QW];
  logic [QW-1:0] q     [QW];
  logic [DW-1:0] dv    [QW];
  logic          ov    [QW];

  logic [DW-1:0] rem_i [QW];
  logic [QW-1:0] lo_i  [QW];
  logic [QW-1:0] q_i   [QW];
  logic [DW-1:0] dv_i  [QW];
  logic          ov_i  [QW];
  logic [DW:0]   trial [QW];
  logic          ge    [QW];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        // quotient wider than QW bits when the top part already reaches den
        rem_i[k] = DW'(num >> QW);
        lo_i[k]  = num[QW-1:0];
        q_i[k]   = '0;
        dv_i[k]  = den;
        ov_i[k]  = (num >> QW) >= NW'(den);
      end else begin
        rem_i[k] = rem[k-1];
        lo_i[k]  = lo[k-1];
        q_i[k]   = q[k-1];
        dv_i[k]  = dv[k-1];
        ov_i[k]  = ov[k-1];
      end
      trial[k] = {rem_i[k], lo_i[k][QW-1]};
      ge[k]    = trial[k] >= {1'b0, dv_i[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem[k] <= ge[k] ? DW'(trial[k] - {1'b0, dv_i[k]}) : DW'(trial[k]);
        lo[k]  <= lo_i[k] << 1;
        q[k]   <= {q_i[k][QW-2:0], ge[k]};
        dv[k]  <= dv_i[k];
        ov[k]  <= ov_i[k];
      end
    end
  end

  assign quo = q[QW-1];
  assign ovf = ov[QW-1];

endmodule

`default_nettype wire

// ----- rtl/core/food_thermal_property_eval.sv -----
// Top level of the food thermal property evaluator pipeline.
`default_nettype none

// Food thermal property evaluator. Each request on the slave stream carries one
// absolute temperature (unsigned Q8 kelvin) and produces one result on the
// master stream: heat capacity (Q16 kJ/(kg K)), thermal conductivity
// (Q16 W/(m K)) and density (Q8 kg/m^3), all saturating, plus a flag in tuser
// that marks an empty composition (zero specific volume), in which case
// conductivity and density read 0. The composition is taken from seven Q16
// mass fractions written through the cfg port (index 0 protein, 1 fat,
// 2 carbohydrate, 3 fiber, 4 ash, 5 liquid water, 6 ice; other indexes are
// dropped); write them only while no request is in flight. The pipeline
// accepts one request per clock unless the master side stalls, and raises its
// result on the master side after 53 register stages; the depth is
// set by two chains of bit-per-stage dividers, 25 stages for the component
// specific volumes and 21 stages for density and conductivity. When the
// master side stalls the whole pipeline holds, and a new request is still
// taken in the cycle the pending result is taken.

module food_thermal_property_eval (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [16:0] temperature
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [18:0] heat_capacity, [36:19] conductivity,
                                 // [56:37] density
  output logic [0:0]  m_tuser,   // [0] empty_composition
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [16:0] cfg_data
);

  localparam int NF    = ftpe_pkg::NFRAC;
  localparam int NC    = ftpe_pkg::NCOMP;
  localparam int NP    = ftpe_pkg::NPOLY;
  localparam int VQ    = 25;          // specific-volume quotient bits
  localparam int DQ    = 21;          // density / conductivity quotient bits
  localparam int S_DIVA = 4;          // stage feeding the volume dividers
  localparam int S_SUM  = S_DIVA + VQ + 2;   // stage holding knum and volume
  localparam int LAT   = S_SUM + DQ + 1;
  localparam int S_HC  = 7;
  localparam int HC_D  = LAT - 1 - S_HC;

  // ---------------------------------------------------------------- control
  logic [LAT-1:0] vld;
  logic           en;

  assign en       = !vld[LAT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // ---------------------------------------------------------- fraction regs
  logic [16:0] frac [NF];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NF; i++) frac[i] <= '0;
    end else if (cfg_we && cfg_addr < ftpe_pkg::ADDR_W'(NF)) begin
      frac[cfg_addr] <= cfg_data;
    end
  end

  // -------------------------------------------- stage 1: Celsius, magnitude
  logic signed [26:0] t16_full;
  logic signed [25:0] t16_1;
  logic [24:0]        mag_1;

  assign t16_full = $signed({2'b0, s_tdata[16:0], 8'b0}) - 27'(ftpe_pkg::ZERO_C_Q16);

  always_ff @(posedge clk) begin
    if (en) begin
      t16_1 <= t16_full[25:0];
      mag_1 <= t16_full[26] ? 25'(-t16_full) : 25'(t16_full);
    end
  end

  // ---------------------------------------------------- stage 2: t squared
  logic [49:0]        sq;
  logic signed [25:0] t16_2;
  logic [33:0]        t2_2;

  assign sq = mag_1 * mag_1;

  always_ff @(posedge clk) begin
    if (en) begin
      t16_2 <= t16_1;
      t2_2  <= sq[49:16];
    end
  end

  // ------------------------------------------ stage 3: linear/square terms
  logic signed [59:0] bt_3 [NP];
  logic signed [59:0] ct_3 [NP];
  logic               neg_3;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NP; i++) begin
        bt_3[i] <= 60'(ftpe_pkg::POLY_B[i] * longint'(t16_2));
        ct_3[i] <= 60'(ftpe_pkg::POLY_C[i] * longint'($signed({30'b0, t2_2})));
      end
      neg_3 <= t16_2[25];
    end
  end

  // ------------------------------------------- stage 4: component values
  longint             pv [NP];
  logic signed [33:0] cp_4  [NF];
  logic signed [27:0] k_4   [NC];
  logic signed [39:0] rho_4 [NC];

  always_comb begin
    for (int i = 0; i < NP; i++) begin
      pv[i] = ((ftpe_pkg::POLY_A[i] <<< 16) + longint'(bt_3[i]) + longint'(ct_3[i])) >>> 24;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < ftpe_pkg::REG_WATER; j++) cp_4[j] <= 34'(pv[j]);
      // water switches to its sub-zero polynomial below 0 C
      cp_4[ftpe_pkg::REG_WATER] <= neg_3 ? 34'(pv[ftpe_pkg::P_WLO])
                                         : 34'(pv[ftpe_pkg::P_WHI]);
      cp_4[ftpe_pkg::REG_ICE]   <= 34'(pv[ftpe_pkg::P_ICE]);
      for (int j = 0; j < NC; j++) begin
        k_4[j]   <= 28'(pv[ftpe_pkg::P_K + j]);
        rho_4[j] <= 40'(pv[ftpe_pkg::P_RHO + j]);
      end
    end
  end

  // ------------------------------------------ heat capacity, stages 5 to 7
  logic signed [51:0] mc_5 [NF];
  logic signed [54:0] hsum_c;
  logic signed [54:0] hsum_6;
  logic signed [30:0] hq;
  logic [18:0]        hc_7;
  logic [18:0]        hcd [HC_D];

  always_comb begin
    hsum_c = '0;
    for (int j = 0; j < NF; j++) hsum_c = hsum_c + 55'(mc_5[j]);
  end

  assign hq = 31'(hsum_6 >>> 24);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NF; j++) mc_5[j] <= $signed({1'b0, frac[j]}) * cp_4[j];
      hsum_6 <= hsum_c;
      if (hsum_6 <= 0) begin
        hc_7 <= '0;
      end else if (hq > 31'(ftpe_pkg::HC_MAX)) begin
        hc_7 <= 19'(ftpe_pkg::HC_MAX);
      end else begin
        hc_7 <= hq[18:0];
      end
      hcd[0] <= hc_7;
      for (int i = 1; i < HC_D; i++) hcd[i] <= hcd[i-1];
    end
  end

  // ---------------------------------- specific volumes, one divider per part
  logic              pos_4 [NC];
  logic [36:0]       va_den [NC];
  logic [VQ-1:0]     va_q [NC];
  logic              va_ovf [NC];
  logic signed [27:0] kd   [VQ][NC];
  logic              posd [VQ][NC];

  genvar g;
  generate
    for (g = 0; g < NC; g++) begin : g_vol
      assign pos_4[g]  = rho_4[g] > 0;
      assign va_den[g] = pos_4[g] ? rho_4[g][36:0] : 37'd1;

      ftpe_div #(
        .NW (57),
        .DW (37),
        .QW (VQ)
      ) u_vdiv (
        .clk (clk),
        .en  (en),
        .num ({frac[g], 40'b0}),
        .den (va_den[g]),
        .quo (va_q[g]),
        .ovf (va_ovf[g])
      );
    end
  endgenerate

  // carry conductivity and the volume-valid bit alongside the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      kd[0]   <= k_4;
      posd[0] <= pos_4;
      for (int i = 1; i < VQ; i++) begin
        kd[i]   <= kd[i-1];
        posd[i] <= posd[i-1];
      end
    end
  end

  // ------------------------------- weighted conductivity and volume sum
  logic [VQ-1:0]      vv [NC];
  logic signed [52:0] kv_30 [NC];
  logic [27:0]        vsum_c;
  logic [27:0]        vsum_30;
  logic signed [55:0] knum_c;
  logic signed [55:0] knum_31;
  logic [27:0]        vol_31;

  always_comb begin
    vsum_c = '0;
    knum_c = '0;
    for (int j = 0; j < NC; j++) begin
      if (!posd[VQ-1][j]) begin
        vv[j] = '0;
      end else if (va_ovf[j]) begin
        vv[j] = '1;
      end else begin
        vv[j] = va_q[j];
      end
      vsum_c = vsum_c + 28'(vv[j]);
      knum_c = knum_c + 56'(kv_30[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NC; j++) begin
        kv_30[j] <= kd[VQ-1][j] * $signed({1'b0, vv[j]});
      end
      vsum_30 <= vsum_c;
      knum_31 <= knum_c;
      vol_31  <= vsum_30;
    end
  end

  // ----------------------------------- density and conductivity dividers
  logic [DQ-1:0] db_q;
  logic          db_ovf;
  logic [DQ-1:0] dc_q;
  logic          dc_ovf;
  logic          kpos_31;
  logic          empd  [DQ];
  logic          kposd [DQ];

  assign kpos_31 = knum_31 > 0;

  ftpe_div #(
    .NW (41),
    .DW (28),
    .QW (DQ)
  ) u_rdiv (
    .clk (clk),
    .en  (en),
    .num ({1'b1, 40'b0}),
    .den (vol_31),
    .quo (db_q),
    .ovf (db_ovf)
  );

  ftpe_div #(
    .NW (55),
    .DW (36),
    .QW (DQ)
  ) u_kdiv (
    .clk (clk),
    .en  (en),
    .num (kpos_31 ? 55'(knum_31) : 55'd0),
    .den ({vol_31, 8'b0}),
    .quo (dc_q),
    .ovf (dc_ovf)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      empd[0]  <= vol_31 == '0;
      kposd[0] <= kpos_31;
      for (int i = 1; i < DQ; i++) begin
        empd[i]  <= empd[i-1];
        kposd[i] <= kposd[i-1];
      end
    end
  end

  // ------------------------------------------------- output register
  logic [18:0] hc_o;
  logic [17:0] kc_o;
  logic [19:0] rho_o;
  logic        emp_o;

  always_ff @(posedge clk) begin
    if (en) begin
      hc_o  <= hcd[HC_D-1];
      emp_o <= empd[DQ-1];
      if (empd[DQ-1]) begin
        rho_o <= '0;
      end else if (db_ovf || db_q > DQ'(ftpe_pkg::RHO_MAX)) begin
        rho_o <= 20'(ftpe_pkg::RHO_MAX);
      end else begin
        rho_o <= db_q[19:0];
      end
      if (empd[DQ-1] || !kposd[DQ-1]) begin
        kc_o <= '0;
      end else if (dc_ovf || dc_q > DQ'(ftpe_pkg::K_MAX)) begin
        kc_o <= 18'(ftpe_pkg::K_MAX);
      end else begin
        kc_o <= dc_q[17:0];
      end
    end
  end

  assign m_tdata = {7'b0, rho_o, kc_o, hc_o};
  assign m_tuser = emp_o;

endmodule

`default_nettype wire

// ----- verif/tb_food_thermal_property_eval.sv -----
// Testbench for the food thermal property evaluator: streamed temperatures, scoreboard check.
`default_nettype none

typedef struct {
  logic [18:0] heat_capacity;
  logic [17:0] conductivity;
  logic [19:0] density;
  logic        empty_composition;
} property_result_t;

// Scoreboard: its own fixed-point copy of the property polynomials, the fraction
// registers, and the queue of property results still owed by the block.
class property_scoreboard;
  longint           coef_a [20];
  longint           coef_b [20];
  longint           coef_c [20];
  longint           frac [ftpe_pkg::NFRAC];
  property_result_t owed [$];
  int               errors;
  int               checked;
  int               empties;

  // Round a decimal ratio to a Q32 magnitude, half up
  static function longint q32(longint unsigned num, longint unsigned den);
    return longint'(((num << 32) + den / 2) / den);
  endfunction

  function new();
    // heat capacity: five solids, water above and below 0 C, ice
    coef_a = '{q32(20082, 10000), q32(19842, 10000), q32(15488, 10000), q32(18459, 10000),
               q32(10926, 10000), q32(41289, 10000), q32(41289, 10000), q32(20623, 10000),
               // conductivity: five solids, water
               q32(17881, 100000), q32(18071, 100000), q32(20141, 100000),
               q32(18331, 100000), q32(32962, 100000), q32(57109, 100000),
               // density: five solids, water
               q32(13299, 10), q32(92559, 100), q32(15991, 10), q32(13115, 10),
               q32(24238, 10), q32(99718, 100)};
    coef_b = '{q32(12089, 64'd10000000), q32(14733, 64'd100000000),
               q32(19625, 64'd10000000), q32(18306, 64'd10000000),
               q32(18896, 64'd10000000), -q32(90864, 64'd1000000000),
               -q32(53062, 64'd10000000), q32(60769, 64'd10000000),
               q32(11958, 64'd10000000), -q32(27604, 64'd100000000),
               q32(13874, 64'd10000000), q32(12497, 64'd10000000),
               q32(14011, 64'd10000000), q32(1762, 64'd1000000),
               -q32(5184, 10000), -q32(41757, 100000), -q32(31046, 100000),
               -q32(36589, 100000), -q32(28063, 100000), q32(31439, 64'd10000000)};
    coef_c = '{-q32(13129, 64'd10000000000), -q32(48008, 64'd10000000000),
               -q32(59399, 64'd10000000000), -q32(46509, 64'd10000000000),
               -q32(36817, 64'd10000000000), q32(54731, 64'd10000000000),
               q32(99516, 64'd100000000), 0,
               -q32(27178, 64'd10000000000), -q32(17749, 64'd100000000000),
               -q32(43312, 64'd10000000000), -q32(31683, 64'd10000000000),
               -q32(29069, 64'd10000000000), -q32(6703, 64'd1000000000),
               0, 0, 0, 0, 0, -q32(37574, 64'd10000000)};
    foreach (frac[i]) frac[i] = 0;
    errors = 0;
    checked = 0;
    empties = 0;
  endfunction

  function void set_fraction(logic [2:0] addr, logic [16:0] value);
    if (addr < ftpe_pkg::NFRAC) frac[addr] = longint'(value);
  endfunction

  // Q24 component property, floored
  function longint poly(int idx, longint t16, longint t2);
    longint acc;
    acc = coef_a[idx] * 65536 + coef_b[idx] * t16 + coef_c[idx] * t2;
    return acc >>> 24;
  endfunction

  function void note_request(logic [16:0] temp);
    longint           t16, t2, hc_sum, k_sum, rho_c;
    longint unsigned  mag, vol, vi, hc, kc, rho;
    property_result_t r;
    t16 = longint'({47'd0, temp}) * 256 - ftpe_pkg::ZERO_C_Q16;
    mag = longint'(t16 < 0 ? -t16 : t16);
    t2 = longint'((mag * mag) >> 16);
    hc_sum = 0;
    k_sum = 0;
    vol = 0;
    for (int i = 0; i < 5; i++) hc_sum += frac[i] * poly(i, t16, t2);
    hc_sum += frac[5] * poly(t16 >= 0 ? ftpe_pkg::P_WHI : ftpe_pkg::P_WLO, t16, t2);
    hc_sum += frac[6] * poly(ftpe_pkg::P_ICE, t16, t2);
    hc = hc_sum <= 0 ? 0 : longint'(hc_sum) >>> 24;
    if (hc > ftpe_pkg::HC_MAX) hc = ftpe_pkg::HC_MAX;
    // conductivity and density are volume weighted and skip ice
    for (int i = 0; i < ftpe_pkg::NCOMP; i++) begin
      rho_c = poly(ftpe_pkg::P_RHO + i, t16, t2);
      vi = 0;
      if (rho_c > 0) vi = (longint'(frac[i]) << 40) / longint'(rho_c);
      if (rho_c > 0) vi = ((frac[i] + 64'd0) << 40) / (rho_c + 64'd0);
      vol += vi;
      k_sum += poly(ftpe_pkg::P_K + i, t16, t2) * longint'(vi);
    end
    if (vol == 0) begin
      r.empty_composition = 1;
      kc = 0;
      rho = 0;
    end else begin
      r.empty_composition = 0;
      rho = (64'd1 << 40) / vol;
      if (rho > ftpe_pkg::RHO_MAX) rho = ftpe_pkg::RHO_MAX;
      kc = k_sum <= 0 ? 0 : (k_sum + 64'd0) / (vol << 8);
      if (kc > ftpe_pkg::K_MAX) kc = ftpe_pkg::K_MAX;
    end
    r.heat_capacity = hc[18:0];
    r.conductivity = kc[17:0];
    r.density = rho[19:0];
    owed.push_back(r);
  endfunction

  function void check_result(logic [63:0] tdata, logic [0:0] tuser);
    property_result_t exp_r;
    checked++;
    if (owed.size() == 0) begin
      $display("%0t: result with nothing owed: tdata %h tuser %b", $time, tdata, tuser);
      errors++;
      return;
    end
    exp_r = owed.pop_front();
    if (exp_r.empty_composition) empties++;
    if (tdata[18:0] !== exp_r.heat_capacity) begin
      $display("%0t: heat_capacity expected %0d actual %0d", $time,
               exp_r.heat_capacity, tdata[18:0]);
      errors++;
    end
    if (tdata[36:19] !== exp_r.conductivity) begin
      $display("%0t: conductivity expected %0d actual %0d", $time,
               exp_r.conductivity, tdata[36:19]);
      errors++;
    end
    if (tdata[56:37] !== exp_r.density) begin
      $display("%0t: density expected %0d actual %0d", $time, exp_r.density, tdata[56:37]);
      errors++;
    end
    if (tuser[0] !== exp_r.empty_composition) begin
      $display("%0t: empty_composition expected %0b actual %0b", $time,
               exp_r.empty_composition, tuser[0]);
      errors++;
    end
  endfunction
endclass

module tb_food_thermal_property_eval;

  localparam int LIMIT_CYCLES = 600000;
  localparam int NPHASE = 11;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [63:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_we = 0;
  logic [2:0]  cfg_addr = '0;
  logic [16:0] cfg_data = '0;

  property_scoreboard sb = new();

  bit idle_on = 1;     // random bursts of idling on both sides
  bit hold_ask = 0;    // main asks the sink for one long hold-off
  int stall_left = 0;
  int hold_left = 0;
  int cycles = 0;
  int sent = 0;

  food_thermal_property_eval dut (.*);

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result sink: check every accepted result, stall in random bursts, and
  // once hold off for a long stretch so the pipeline fills and backs up.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if (hold_ask) begin
        hold_ask = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        m_tready <= 0;
      end else begin
        m_tready <= 1;
      end
    end
  end

  // Offer one temperature request and hold it until accepted
  task automatic send_temperature(logic [16:0] temp);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 18);
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {7'd0, temp};
    do @(posedge clk); while (!s_tready);
    sb.note_request(temp);
    sent++;
  endtask

  // Wait until every owed result is back, then let the pipeline settle
  task automatic drain();
    s_tvalid <= 0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Hold the write enable high; the caller drops it after the last write
  task automatic write_fraction(logic [2:0] addr, logic [16:0] value);
    cfg_we <= 1;
    cfg_addr <= addr;
    cfg_data <= value;
    @(posedge clk);
    sb.set_fraction(addr, value);
  endtask

  logic [16:0] directed_temps [12] = '{17'd0, 17'd131071, 17'd59686, 17'd108326,
                                       17'd69926, 17'd69927, 17'd69925, 17'd69928,
                                       17'd1, 17'd65536, 17'd100000, 17'd131070};

  // Fraction settings per phase: protein, fat, carbohydrate, fiber, ash, water, ice.
  // Phase 0 keeps the reset values; later phases past the table are random.
  logic [16:0] phase_fracs [8][ftpe_pkg::NFRAC] = '{
    '{17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0},
    '{17'd13107, 17'd6554, 17'd655, 17'd0, 17'd655, 17'd45875, 17'd0},
    '{17'd9830, 17'd3277, 17'd1311, 17'd655, 17'd655, 17'd9830, 17'd39322},
    '{17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536},
    '{17'd131071, 17'd131071, 17'd131071, 17'd131071, 17'd131071, 17'd131071,
      17'd131071},
    '{17'd1, 17'd1, 17'd1, 17'd1, 17'd1, 17'd1, 17'd1},
    '{17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd65536},
    '{17'd0, 17'd65536, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0}
  };

  initial begin
    logic [16:0] temp;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (int ph = 0; ph < NPHASE; ph++) begin
      if (ph == NPHASE - 1) idle_on = 0;  // last phase runs at full rate
      if (ph > 0) begin
        drain();
        for (int r = 0; r < ftpe_pkg::NFRAC; r++) begin
          write_fraction(r[2:0], ph < 8 ? phase_fracs[ph][r] :
                         ($urandom_range(0, 3) == 0 ? 17'd0 : 17'($urandom_range(0, 70000))));
        end
        // unknown register index: must be dropped
        write_fraction(3'd7, 17'($urandom));
        cfg_we <= 0;
      end
      if (ph <= 1) begin
        foreach (directed_temps[i]) send_temperature(directed_temps[i]);
      end
      if (ph == 3) hold_ask = 1;
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 7) == 0) temp = 17'($urandom_range(0, 131071));
        else temp = 17'($urandom_range(59686, 108326));
        send_temperature(temp);
      end
    end
    drain();
    $display("Sent %0d temperatures over %0d fraction settings; %0d results checked, %0d empty.",
             sent, NPHASE, sb.checked, sb.empties);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- food_thermal_property_eval.f -----
rtl/core/ftpe_pkg.sv
rtl/core/ftpe_div.sv
rtl/core/food_thermal_property_eval.sv
verif/tb_food_thermal_property_eval.sv
